FILE: rtl/scc_pkg.sv
// Shared types and constants for the wavetable sound generator.
// No dependencies; imported by every module of the block.
package scc_pkg;

  localparam int CHANNELS      = 5;
  localparam int WAVE_LENGTH   = 32;
  localparam int WAVE_DEPTH    = CHANNELS * WAVE_LENGTH;
  localparam int WAVE_AW       = $clog2(WAVE_DEPTH);
  localparam int FRAC_DEFAULT  = 16;
  localparam int CLOCK_W       = 26;
  localparam int FREQ_W        = 12;
  localparam int RATE_W        = CLOCK_W - 4;
  localparam int DEN_W         = FREQ_W + 1 + RATE_W;
  localparam int MIX_W         = 15;

  localparam logic [CLOCK_W-1:0] CLOCK_RESET = 26'd3579545;

  localparam logic [2:0] PORT_WAVE = 3'd0;
  localparam logic [2:0] PORT_FREQ = 3'd1;
  localparam logic [2:0] PORT_VOL  = 3'd2;
  localparam logic [2:0] PORT_KEY  = 3'd3;
  localparam logic [2:0] PORT_TEST = 3'd5;

  localparam logic       CFG_CLOCK = 1'b0;
  localparam logic       CFG_PLUS  = 1'b1;

  localparam logic [7:0] SHARED_WAVE_BASE = 8'h60;

  typedef struct packed {
    logic               en;
    logic [WAVE_AW-1:0] addr;
    logic [7:0]         data;
  } scc_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
  } scc_div_st_t;

endpackage

FILE: rtl/scc_wave_ram.sv
// Wave sample memory, one write and one registered read port.
// Per-entry valid bits give zero for entries never written. Uses scc_pkg.
module scc_wave_ram import scc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  scc_wr_t            wr,
  input  logic               rd_en,
  input  logic [WAVE_AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0]            mem [WAVE_DEPTH];
  logic [WAVE_DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

endmodule

FILE: rtl/scc_div.sv
// Restoring divider, one quotient bit per cycle, low 32 quotient bits kept.
// Uses scc_pkg for the status struct.
module scc_div import scc_pkg::*; #(
  parameter int NUM_W = 43,
  parameter int DEN_WD = 35
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_WD-1:0] den,
  output scc_div_st_t       st,
  output logic [31:0]       quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]     cnt;
  logic [NUM_W-1:0]  numsh;
  logic [DEN_WD-1:0] rem;
  logic              busy, done;
  logic [DEN_WD:0]   rem_sh;
  logic [DEN_WD+1:0] diff;
  logic              take;

  always_comb begin
    rem_sh = {rem, numsh[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den};
    take   = !diff[DEN_WD+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(NUM_W);
        numsh <= num;
        rem   <= '0;
        quo   <= '0;
      end else if (busy) begin
        numsh <= numsh << 1;
        rem   <= take ? diff[DEN_WD-1:0] : rem_sh[DEN_WD-1:0];
        quo   <= {quo[30:0], take};
        cnt   <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign st = '{busy: busy, done: done};

endmodule

FILE: rtl/wavetable_sound_generator_core.sv
// Top level: register file, render sequencer, mixer and output register.
// Depends on scc_pkg, scc_div and scc_wave_ram.
//
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------
//  in      | in_valid / in_stall     | req_type, port, reg_addr, wdata
//  out     | out_valid / out_stall   | sample
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A register write is taken in S_IDLE; a shared channel 3/4 wave write
// also writes channel 4 from S_WR2. A render walks the channels in turn;
// an active channel passes S_CHK, S_MUL, S_DIVW while the divider runs,
// S_RD and S_RDW, an idle one only S_CHK.
// Reset clears control and channel state; the wave memory uses valid bits.
// A stalled output word holds the render in its final state.
module wavetable_sound_generator_core import scc_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         req_type,
  input  logic [2:0]   port,
  input  logic [7:0]   reg_addr,
  input  logic [7:0]   wdata,
  output logic         out_valid,
  input  logic         out_stall,
  output logic signed [7:0] sample,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [CLOCK_W-1:0] cfg_data
);

  localparam int NUM_W = CLOCK_W + FRACTION_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_WR2, S_CHK, S_MUL, S_DIVW, S_RD, S_RDW, S_FIN
  } state_t;

  state_t state;
  logic [CLOCK_W-1:0] clk_freq;
  logic               plus_mode;
  logic [FREQ_W-1:0]  freq_div    [CHANNELS];
  logic [3:0]         chan_volume [CHANNELS];
  logic [CHANNELS-1:0] chan_key;
  logic [31:0]        phase_count [CHANNELS];
  logic [7:0]         test_byte;
  logic [2:0]         chan;
  logic signed [MIX_W-1:0] mix;
  logic [DEN_W-1:0]   den;
  logic [7:0]         wr2_data;
  logic [4:0]         wr2_idx;

  scc_wr_t      wr;
  logic         rd_en;
  logic [7:0]   rd_data;
  logic         div_start;
  scc_div_st_t  div_st;
  logic [31:0]  quo;

  logic         in_acc;
  logic [6:0]   fch;
  logic [FREQ_W-1:0] freq_new;
  logic         active;
  logic [4:0]   offs;
  logic signed [12:0] prod;
  logic signed [MIX_W-5:0] mix_sh;
  logic signed [7:0] sat;
  logic [31:0]  frac_mask;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign frac_mask = 32'((64'd1 << FRACTION_BITS) - 64'd1);
  assign fch       = reg_addr[7:1];

  always_comb begin
    freq_new = '0;
    if (fch < 7'(CHANNELS)) begin
      freq_new = reg_addr[0] ? {wdata[3:0], freq_div[fch[2:0]][7:0]}
                             : {freq_div[fch[2:0]][11:8], wdata};
    end
  end

  assign active = (freq_div[chan] > FREQ_W'(8)) && chan_key[chan] &&
                  (chan_volume[chan] != 4'd0);
  assign offs   = phase_count[chan][FRACTION_BITS +: 5];
  assign prod   = $signed(rd_data) * $signed({1'b0, chan_volume[chan]});
  // floor divide by 16: drop the low four bits of the signed sum
  assign mix_sh = mix[MIX_W-1:4];

  always_comb begin
    if (mix_sh > 11'sd127) sat = 8'sd127;
    else if (mix_sh < -11'sd128) sat = -8'sd128;
    else sat = mix_sh[7:0];
  end

  // wave memory write request
  always_comb begin
    wr = '{en: 1'b0, addr: '0, data: wdata};
    if (state == S_WR2) begin
      wr = '{en: 1'b1, addr: WAVE_AW'({3'd4, wr2_idx}), data: wr2_data};
    end else if (in_acc && !req_type && port == PORT_WAVE && !test_byte[6]) begin
      if (!plus_mode && reg_addr >= SHARED_WAVE_BASE) begin
        wr.en   = 1'b1;
        wr.addr = WAVE_AW'({3'd3, reg_addr[4:0]});
      end else if (reg_addr[7:5] < 3'(CHANNELS)) begin
        wr.en   = 1'b1;
        wr.addr = WAVE_AW'({reg_addr[7:5], reg_addr[4:0]});
      end
    end
  end

  assign rd_en     = (state == S_RD);
  assign div_start = (state == S_MUL) && (clk_freq[CLOCK_W-1:4] != '0);

  scc_wave_ram u_ram (
    .clk(clk), .rst(rst), .wr(wr), .rd_en(rd_en),
    .rd_addr(WAVE_AW'({chan, offs})), .rd_data(rd_data)
  );

  scc_div #(.NUM_W(NUM_W), .DEN_WD(DEN_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num({clk_freq, {(FRACTION_BITS + 1){1'b0}}}), .den(den),
    .st(div_st), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clk_freq  <= CLOCK_RESET;
      plus_mode <= 1'b0;
      chan_key  <= '0;
      test_byte <= '0;
      out_valid <= 1'b0;
      chan      <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        freq_div[i]    <= '0;
        chan_volume[i] <= '0;
        phase_count[i] <= '0;
      end
    end else begin
      if (state == S_FIN && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CLOCK) clk_freq <= cfg_data;
        else plus_mode <= cfg_data[0];
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (req_type) begin
              chan  <= '0;
              mix   <= '0;
              state <= S_CHK;
            end else begin
              case (port)
                PORT_WAVE: begin
                  if (!test_byte[6] && !plus_mode && reg_addr >= SHARED_WAVE_BASE) begin
                    wr2_data <= wdata;
                    wr2_idx  <= reg_addr[4:0];
                    state    <= S_WR2;
                  end
                end
                PORT_FREQ: begin
                  if (fch < 7'(CHANNELS)) begin
                    freq_div[fch[2:0]] <= freq_new;
                    if (test_byte[5]) phase_count[fch[2:0]] <= 32'hFFFF_FFFF;
                    else if (freq_new < FREQ_W'(9))
                      phase_count[fch[2:0]] <= phase_count[fch[2:0]] | frac_mask;
                  end
                end
                PORT_VOL: begin
                  if (reg_addr[2:0] < 3'(CHANNELS)) chan_volume[reg_addr[2:0]] <= wdata[3:0];
                end
                PORT_KEY:  chan_key  <= wdata[CHANNELS-1:0];
                PORT_TEST: test_byte <= wdata;
                default: ;
              endcase
            end
          end
        end
        S_WR2: state <= S_IDLE;
        S_CHK: begin
          den <= DEN_W'({1'b0, freq_div[chan]} + 13'd1) * DEN_W'(clk_freq[CLOCK_W-1:4]);
          if (active) state <= S_MUL;
          else if (chan == 3'(CHANNELS - 1)) state <= S_FIN;
          else chan <= chan + 3'd1;
        end
        S_MUL: state <= div_start ? S_DIVW : S_RD;
        S_DIVW: begin
          if (div_st.done) begin
            phase_count[chan] <= phase_count[chan] + quo;
            state <= S_RD;
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          mix <= mix + MIX_W'(prod);
          if (chan == 3'(CHANNELS - 1)) state <= S_FIN;
          else begin
            chan  <= chan + 3'd1;
            state <= S_CHK;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            sample <= sat;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_render_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc && req_type |=> state == S_CHK) else $error("render not started");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy) else $error("divider restarted while busy");
  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> chan < 3'(CHANNELS)) else $error("channel out of range");
  a_out_once: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && (!out_valid || !out_stall) |=> out_valid && state == S_IDLE)
    else $error("result not delivered");

endmodule
